// ===== design/protobuf_sensor_reading_parser_unit_defines.svh =====
// assertion macros shared by the parser unit rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef PROTOBUF_SENSOR_READING_PARSER_UNIT_DEFINES_SVH
`define PROTOBUF_SENSOR_READING_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// check at every clock edge, reset included
`define PBSR_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
// check outside of reset only
`define PBSR_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define PBSR_ASSERT(label, clk, prop, msg)
`define PBSR_ASSERT_RST(label, clk, rst_n, prop, msg)
`endif

`endif

// ===== design/pbsr_pkg.sv =====
// shared types and wire-format constants of the sensor reading parser
// no dependencies
package pbsr_pkg;

    // wire format
    localparam int          FAT_W           = 35;
    localparam logic [3:0]  VARINT_LAST_IDX = 4'd9;
    localparam logic [3:0]  FIXED_BYTES     = 4'd4;
    localparam logic [2:0]  WT_VARINT       = 3'd0;
    localparam logic [2:0]  WT_LEN          = 3'd2;
    localparam logic [2:0]  WT_FIXED32      = 3'd5;

    // field numbers
    localparam logic [31:0] FIELD_READING   = 32'd2;
    localparam logic [31:0] FIELD_CHANNEL   = 32'd1;
    localparam logic [31:0] FIELD_RAW       = 32'd2;
    localparam logic [31:0] FIELD_CAL       = 32'd3;

    // input commands
    localparam logic        CMD_BYTE        = 1'b0;
    localparam logic        CMD_READ        = 1'b1;

    // reading offered by the parser for the cache
    typedef struct packed {
        logic        en;
        logic [7:0]  channel;
        logic [31:0] raw;
        logic [31:0] cal;
    } t_commit;

endpackage

// ===== design/protobuf_sensor_reading_parser_unit.sv =====
// Sensor reading parser: walks a protobuf message one byte a beat and keeps the last
// reading of every channel in a cache ram; a read beat returns one cache entry. Every
// beat, byte or read, gives exactly one result beat, and a new beat is taken in every
// cycle as long as the output register is free or being emptied, so the sustained rate
// is one beat per cycle. A result appears in the cycle after its beat is accepted, from the
// result register and the registered cache ram read. Cache valid bits live in flip-flops and
// clear at reset, so the block is ready straight out of reset with no clearing pass.
// depends on pbsr_pkg, pbsr_parser, pbsr_ram and the assertion macro header
`include "protobuf_sensor_reading_parser_unit_defines.svh"

module protobuf_sensor_reading_parser_unit #(
    parameter int CHANNELS    = 4,
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [7:0]  i_read_channel,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_updated,
    output logic [7:0]  o_channel_number,
    output logic [31:0] o_raw_reading,
    output logic [31:0] o_calibrated_bits,
    output logic        o_message_done,
    output logic [31:0] o_message_count,
    output logic        o_bad_channel
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    pbsr_pkg::t_commit commit;
    logic              msg_done;
    logic [31:0]       msg_count;
    logic              in_acc;
    logic              step;
    logic              rd;
    logic              rd_in_range;
    logic [CH_W-1:0]   rd_idx;
    logic              upd;
    logic [CH_W-1:0]   wr_idx;
    logic              ram_we;
    logic              ram_re;
    logic [63:0]       ram_q;

    logic              r_out_valid;
    logic              r_written [CHANNELS];
    logic              r_upd;
    logic [7:0]        r_ch;
    logic [31:0]       r_raw;
    logic [31:0]       r_cal;
    logic              r_done;
    logic [31:0]       r_count;
    logic              r_bad;
    logic              r_hit;

    // input handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign step       = in_acc && (i_command == pbsr_pkg::CMD_BYTE);
    assign rd         = in_acc && (i_command == pbsr_pkg::CMD_READ);

    pbsr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_commit    (commit),
        .o_msg_done  (msg_done),
        .o_msg_count (msg_count)
    );

    // cache addressing
    assign rd_in_range = ({1'b0, i_read_channel} < 9'(CHANNELS));
    assign rd_idx      = i_read_channel[CH_W-1:0];
    assign upd         = commit.en && ({1'b0, commit.channel} < 9'(CHANNELS));
    assign wr_idx      = commit.channel[CH_W-1:0];
    assign ram_we      = step && upd;
    assign ram_re      = rd && rd_in_range;

    pbsr_ram #(
        .WIDTH (64),
        .DEPTH (CHANNELS)
    ) u_cache (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata ({commit.raw, commit.cal}),
        .i_re    (ram_re),
        .i_raddr (rd_idx),
        .o_rdata (ram_q)
    );

    // control state: output valid and cache valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_written[i] <= 1'b0;
            end
        end else begin
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_written[wr_idx] <= 1'b1;
            end
        end
    end

    // result register; ram read data arrives alongside it from the registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_upd   <= ram_we;
            r_done  <= msg_done;
            r_count <= msg_count;
            r_bad   <= rd && !rd_in_range;
            r_hit   <= rd && rd_in_range && r_written[rd_idx];
            r_raw   <= ram_we ? commit.raw : 32'd0;
            r_cal   <= ram_we ? commit.cal : 32'd0;
            if (ram_we) begin
                r_ch <= commit.channel;
            end else if (rd && rd_in_range && r_written[rd_idx]) begin
                r_ch <= i_read_channel;
            end else begin
                r_ch <= 8'd0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_updated         = r_upd;
    assign o_channel_number  = r_ch;
    assign o_raw_reading     = r_hit ? ram_q[63:32] : r_raw;
    assign o_calibrated_bits = r_hit ? ram_q[31:0] : r_cal;
    assign o_message_done    = r_done;
    assign o_message_count   = r_count;
    assign o_bad_channel     = r_bad;

    // checks
    `PBSR_ASSERT(a_no_read_write_overlap, i_clk, !(ram_we && ram_re),
        "cache read and write in one beat")
    `PBSR_ASSERT_RST(a_commit_marks_valid, i_clk, i_rst_n,
        (ram_we && i_rst_n) |=> r_written[$past(wr_idx)], "commit did not set valid bit")
    `PBSR_ASSERT_RST(a_read_result_clean, i_clk, i_rst_n,
        (o_out_valid && r_hit) |-> (!o_updated && !o_bad_channel && !o_message_done),
        "read hit mixed with byte result")
    `PBSR_ASSERT_RST(a_last_gives_done, i_clk, i_rst_n,
        (step && i_last_byte && i_rst_n) |=> (o_out_valid && o_message_done),
        "message end not reported")

endmodule

// ===== design/pbsr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module pbsr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pbsr_parser.sv =====
// byte-wise wire-format walker: outer message, reading sub-message, staging
// depends on pbsr_pkg
module pbsr_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output pbsr_pkg::t_commit   o_commit,
    output logic                o_msg_done,
    output logic [31:0]         o_msg_count
);

    localparam int LB = LENGTH_BITS;
    localparam int FW = pbsr_pkg::FAT_W;

    typedef enum logic [2:0] {
        M_TAG, M_VARINT, M_LEN, M_SKIP, M_FIXED, M_SUB, M_HALT
    } t_mode;

    t_mode          r_outer, n_outer;
    t_mode          r_inner, n_inner;
    logic [FW-1:0]  r_vval, n_vval;
    logic           r_vhigh, n_vhigh;
    logic [3:0]     r_vcnt, n_vcnt;
    logic [FW-1:0]  r_fat, n_fat;
    logic [LB-1:0]  r_skip, n_skip;
    logic [LB-1:0]  r_sub, n_sub;
    logic [31:0]    r_fixed, n_fixed;
    logic [7:0]     r_st_ch, n_st_ch;
    logic [31:0]    r_st_raw, n_st_raw;
    logic [31:0]    r_st_cal, n_st_cal;
    logic [31:0]    r_count, n_count;

    logic [6:0]     v_shamt;
    logic [FW-1:0]  acc_val;
    logic           acc_high;
    logic           acc_zero;
    logic           v_done;
    logic           v_err;
    logic           len_big;
    logic           inner_ge;
    logic [LB-1:0]  sub_dec;
    logic [LB-1:0]  skip_dec;
    logic [31:0]    fx;
    logic [3:0]     fx_cnt;
    logic [31:0]    field;
    logic           use_var;
    logic           sub_end;
    logic           commit_req;

    // varint accumulation: low 35 bits kept, anything above folds to a sticky flag
    assign v_shamt  = {3'b000, r_vcnt} * 7'd7;
    assign acc_val  = r_vval | (FW'(i_data_byte[6:0]) << v_shamt);
    assign acc_high = r_vhigh
                    | ((r_vcnt >= 4'd5) && (r_vcnt <= 4'd8) && (i_data_byte[6:0] != 7'd0))
                    | ((r_vcnt == pbsr_pkg::VARINT_LAST_IDX) && i_data_byte[0]);
    assign acc_zero = !acc_high && (acc_val == '0);
    assign v_done   = !i_data_byte[7];
    assign v_err    = i_data_byte[7] && (r_vcnt == pbsr_pkg::VARINT_LAST_IDX);

    // length checks
    assign len_big  = acc_high || ((acc_val >> LB) != '0);
    assign sub_dec  = (r_sub != '0) ? r_sub - LB'(1) : '0;
    assign inner_ge = len_big || (acc_val[LB-1:0] >= sub_dec);
    assign skip_dec = (r_skip != '0) ? r_skip - LB'(1) : '0;
    assign field    = r_fat[FW-1:3];
    assign fx       = {i_data_byte, r_fixed[31:8]};
    assign fx_cnt   = r_vcnt + 4'd1;

    // next-state logic for one payload byte
    always_comb begin
        n_outer    = r_outer;
        n_inner    = r_inner;
        n_vval     = r_vval;
        n_vhigh    = r_vhigh;
        n_vcnt     = r_vcnt;
        n_fat      = r_fat;
        n_skip     = r_skip;
        n_sub      = r_sub;
        n_fixed    = r_fixed;
        n_st_ch    = r_st_ch;
        n_st_raw   = r_st_raw;
        n_st_cal   = r_st_cal;
        n_count    = r_count;
        use_var    = 1'b0;
        sub_end    = 1'b0;
        commit_req = 1'b0;

        if (i_step) begin
            unique case (r_outer)
                M_TAG: begin
                    use_var = 1'b1;
                    if (v_err) begin
                        n_outer = M_HALT;
                    end else if (v_done) begin
                        n_fat = acc_val;
                        case (acc_val[2:0])
                            pbsr_pkg::WT_VARINT: n_outer = M_VARINT;
                            pbsr_pkg::WT_LEN:    n_outer = M_LEN;
                            pbsr_pkg::WT_FIXED32: begin
                                n_skip  = LB'(pbsr_pkg::FIXED_BYTES);
                                n_outer = M_SKIP;
                            end
                            default:             n_outer = M_HALT;
                        endcase
                    end
                end
                M_VARINT: begin
                    use_var = 1'b1;
                    if (v_err) begin
                        n_outer = M_HALT;
                    end else if (v_done) begin
                        n_outer = M_TAG;
                    end
                end
                M_LEN: begin
                    use_var = 1'b1;
                    if (v_err) begin
                        n_outer = M_HALT;
                    end else if (v_done) begin
                        if (len_big) begin
                            n_outer = M_HALT;
                        end else if (field == pbsr_pkg::FIELD_READING) begin
                            n_st_ch  = '0;
                            n_st_raw = '0;
                            n_st_cal = '0;
                            if (acc_zero) begin
                                commit_req = 1'b1;
                                n_outer    = M_TAG;
                            end else begin
                                n_sub   = acc_val[LB-1:0];
                                n_inner = M_TAG;
                                n_outer = M_SUB;
                            end
                        end else if (acc_zero) begin
                            n_outer = M_TAG;
                        end else begin
                            n_skip  = acc_val[LB-1:0];
                            n_outer = M_SKIP;
                        end
                    end
                end
                M_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_outer = M_TAG;
                    end
                end
                M_SUB: begin
                    n_sub = sub_dec;
                    // reading sub-message walker
                    unique case (r_inner)
                        M_TAG: begin
                            use_var = 1'b1;
                            if (v_err) begin
                                n_inner = M_HALT;
                            end else if (v_done) begin
                                n_fat = acc_val;
                                case (acc_val[2:0])
                                    pbsr_pkg::WT_VARINT: n_inner = M_VARINT;
                                    pbsr_pkg::WT_LEN:    n_inner = M_LEN;
                                    pbsr_pkg::WT_FIXED32: begin
                                        n_fixed = '0;
                                        n_inner = M_FIXED;
                                    end
                                    default:             n_inner = M_HALT;
                                endcase
                            end
                        end
                        M_VARINT: begin
                            use_var = 1'b1;
                            if (v_err) begin
                                n_inner = M_HALT;
                            end else if (v_done) begin
                                if (field == pbsr_pkg::FIELD_CHANNEL) begin
                                    n_st_ch = acc_val[7:0];
                                end else if (field == pbsr_pkg::FIELD_RAW) begin
                                    n_st_raw = acc_val[31:0];
                                end
                                n_inner = M_TAG;
                            end
                        end
                        M_LEN: begin
                            use_var = 1'b1;
                            if (v_err) begin
                                n_inner = M_HALT;
                            end else if (v_done) begin
                                if (acc_zero) begin
                                    n_inner = M_TAG;
                                end else if (inner_ge) begin
                                    n_inner = M_HALT;
                                end else begin
                                    n_skip  = acc_val[LB-1:0];
                                    n_inner = M_SKIP;
                                end
                            end
                        end
                        M_SKIP: begin
                            n_skip = skip_dec;
                            if (skip_dec == '0) begin
                                n_inner = M_TAG;
                            end
                        end
                        M_FIXED: begin
                            // little-endian float bits, byte counter shares the varint count
                            n_fixed = fx;
                            if (fx_cnt >= pbsr_pkg::FIXED_BYTES) begin
                                n_vcnt = '0;
                                if (field == pbsr_pkg::FIELD_CAL) begin
                                    n_st_cal = fx;
                                end
                                n_inner = M_TAG;
                            end else begin
                                n_vcnt = fx_cnt;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (sub_dec == '0) begin
                        sub_end    = 1'b1;
                        commit_req = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // varint register update
            if (use_var) begin
                if (v_done || v_err) begin
                    n_vval  = '0;
                    n_vhigh = 1'b0;
                    n_vcnt  = '0;
                end else begin
                    n_vval  = acc_val;
                    n_vhigh = acc_high;
                    n_vcnt  = fx_cnt;
                end
            end

            // sub-message end returns both walkers to tag
            if (sub_end) begin
                n_vval  = '0;
                n_vhigh = 1'b0;
                n_vcnt  = '0;
                n_skip  = '0;
                n_inner = M_TAG;
                n_outer = M_TAG;
            end
        end

        // staged reading as seen after this byte
        o_commit.en      = commit_req;
        o_commit.channel = n_st_ch;
        o_commit.raw     = n_st_raw;
        o_commit.cal     = n_st_cal;

        // message end clears every parse register
        if (i_step && i_last_byte) begin
            n_outer  = M_TAG;
            n_inner  = M_TAG;
            n_vval   = '0;
            n_vhigh  = 1'b0;
            n_vcnt   = '0;
            n_fat    = '0;
            n_skip   = '0;
            n_sub    = '0;
            n_fixed  = '0;
            n_st_ch  = '0;
            n_st_raw = '0;
            n_st_cal = '0;
            n_count  = r_count + 32'd1;
        end
    end

    assign o_msg_done  = i_step && i_last_byte;
    assign o_msg_count = n_count;

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer  <= M_TAG;
            r_inner  <= M_TAG;
            r_vval   <= '0;
            r_vhigh  <= 1'b0;
            r_vcnt   <= '0;
            r_fat    <= '0;
            r_skip   <= '0;
            r_sub    <= '0;
            r_fixed  <= '0;
            r_st_ch  <= '0;
            r_st_raw <= '0;
            r_st_cal <= '0;
            r_count  <= '0;
        end else begin
            r_outer  <= n_outer;
            r_inner  <= n_inner;
            r_vval   <= n_vval;
            r_vhigh  <= n_vhigh;
            r_vcnt   <= n_vcnt;
            r_fat    <= n_fat;
            r_skip   <= n_skip;
            r_sub    <= n_sub;
            r_fixed  <= n_fixed;
            r_st_ch  <= n_st_ch;
            r_st_raw <= n_st_raw;
            r_st_cal <= n_st_cal;
            r_count  <= n_count;
        end
    end

endmodule

// ===== tb/pbsr_reading_checker.sv =====
`timescale 1ns / 100ps
// result checker for the sensor reading parser: follows the wire-format walk and the
// channel cache beat by beat and compares each result beat with the oldest prediction
// depends on pbsr_pkg
module pbsr_reading_checker #(
    parameter int CHANNELS    = 4,
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [7:0]  i_read_channel,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_updated,
    input  logic [7:0]  i_channel_number,
    input  logic [31:0] i_raw_reading,
    input  logic [31:0] i_calibrated_bits,
    input  logic        i_message_done,
    input  logic [31:0] i_message_count,
    input  logic        i_bad_channel,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [63:0] LEN_LIMIT = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam int          FW        = pbsr_pkg::FAT_W;

    typedef enum logic [2:0] {
        WALK_TAG, WALK_VARINT, WALK_LEN, WALK_SKIP, WALK_FIXED, WALK_SUB, WALK_HALT
    } t_walk_mode;

    typedef enum logic [1:0] {VARINT_MORE, VARINT_DONE, VARINT_BAD} t_varint_status;

    typedef struct packed {
        logic        updated;
        logic [7:0]  channel;
        logic [31:0] raw;
        logic [31:0] cal;
        logic        done;
        logic [31:0] count;
        logic        bad;
    } t_reading_beat;

    // walk state of the message and of the reading sub-message
    t_walk_mode     top_mode;
    t_walk_mode     sub_mode;
    logic [63:0]    acc_value;
    logic [3:0]     acc_count;
    logic [FW-1:0]  tag_word;
    logic [31:0]    skip_left;
    logic [31:0]    sub_left;
    logic [31:0]    fixed_word;
    logic [7:0]     stg_channel;
    logic [31:0]    stg_raw;
    logic [31:0]    stg_cal;

    // channel cache
    logic [31:0]    cache_raw [CHANNELS];
    logic [31:0]    cache_cal [CHANNELS];
    logic           cache_valid [CHANNELS];
    logic [31:0]    msg_count;

    t_reading_beat  predicted_readings [$];
    int             fail_total;

    assign o_fail_count = fail_total;

    // one byte into the varint accumulator
    function automatic t_varint_status absorb_varint(input logic [7:0] b);
        acc_value = acc_value | (64'(b[6:0]) << (7 * acc_count));
        acc_count = acc_count + 4'd1;
        if (!b[7]) return VARINT_DONE;
        if (acc_count > pbsr_pkg::VARINT_LAST_IDX) return VARINT_BAD;
        return VARINT_MORE;
    endfunction

    function automatic logic [63:0] drain_varint();
        logic [63:0] v;
        v = acc_value;
        acc_value = '0;
        acc_count = '0;
        return v;
    endfunction

    function automatic logic [31:0] field_of_tag();
        return tag_word[FW-1:3];
    endfunction

    task automatic clear_walk();
        top_mode    = WALK_TAG;
        sub_mode    = WALK_TAG;
        acc_value   = '0;
        acc_count   = '0;
        tag_word    = '0;
        skip_left   = '0;
        sub_left    = '0;
        fixed_word  = '0;
        stg_channel = '0;
        stg_raw     = '0;
        stg_cal     = '0;
    endtask

    task automatic reset_model();
        clear_walk();
        for (int i = 0; i < CHANNELS; i++) begin
            cache_raw[i]   = '0;
            cache_cal[i]   = '0;
            cache_valid[i] = 1'b0;
        end
        msg_count = '0;
    endtask

    // staged reading goes to the cache only for a channel that exists
    function automatic logic store_reading();
        if (32'(stg_channel) >= CHANNELS) return 1'b0;
        cache_raw[stg_channel]   = stg_raw;
        cache_cal[stg_channel]   = stg_cal;
        cache_valid[stg_channel] = 1'b1;
        return 1'b1;
    endfunction

    // byte inside a reading sub-message, sub_left already excludes it
    task automatic walk_sub_byte(input logic [7:0] b);
        t_varint_status st;
        logic [63:0]    v;
        case (sub_mode)
            WALK_TAG: begin
                st = absorb_varint(b);
                if (st == VARINT_BAD) begin
                    void'(drain_varint());
                    sub_mode = WALK_HALT;
                end else if (st == VARINT_DONE) begin
                    v = drain_varint();
                    tag_word = v[FW-1:0];
                    case (tag_word[2:0])
                        pbsr_pkg::WT_VARINT: sub_mode = WALK_VARINT;
                        pbsr_pkg::WT_LEN:    sub_mode = WALK_LEN;
                        pbsr_pkg::WT_FIXED32: begin
                            sub_mode   = WALK_FIXED;
                            fixed_word = '0;
                            acc_count  = '0;
                        end
                        default:   sub_mode = WALK_HALT;
                    endcase
                end
            end
            WALK_VARINT: begin
                st = absorb_varint(b);
                if (st == VARINT_BAD) begin
                    void'(drain_varint());
                    sub_mode = WALK_HALT;
                end else if (st == VARINT_DONE) begin
                    v = drain_varint();
                    if (field_of_tag() == pbsr_pkg::FIELD_CHANNEL) stg_channel = v[7:0];
                    else if (field_of_tag() == pbsr_pkg::FIELD_RAW) stg_raw = v[31:0];
                    sub_mode = WALK_TAG;
                end
            end
            WALK_FIXED: begin
                fixed_word = {b, fixed_word[31:8]};
                acc_count  = acc_count + 4'd1;
                if (acc_count >= pbsr_pkg::FIXED_BYTES) begin
                    acc_count = '0;
                    if (field_of_tag() == pbsr_pkg::FIELD_CAL) stg_cal = fixed_word;
                    sub_mode = WALK_TAG;
                end
            end
            WALK_LEN: begin
                st = absorb_varint(b);
                if (st == VARINT_BAD) begin
                    void'(drain_varint());
                    sub_mode = WALK_HALT;
                end else if (st == VARINT_DONE) begin
                    v = drain_varint();
                    if (v == 64'd0) sub_mode = WALK_TAG;
                    else if (v >= 64'(sub_left)) sub_mode = WALK_HALT;
                    else begin
                        skip_left = v[31:0];
                        sub_mode  = WALK_SKIP;
                    end
                end
            end
            WALK_SKIP: begin
                if (skip_left > 0) skip_left = skip_left - 1;
                if (skip_left == 0) sub_mode = WALK_TAG;
            end
            default: ;
        endcase
    endtask

    // expected result of one accepted beat
    task automatic parse_beat(input logic cmd, input logic [7:0] b, input logic last,
                              input logic [7:0] rch, output t_reading_beat r);
        logic           upd;
        t_varint_status st;
        logic [63:0]    v;
        r   = '0;
        upd = 1'b0;
        if (cmd == pbsr_pkg::CMD_READ) begin
            if (32'(rch) >= CHANNELS) begin
                r.bad = 1'b1;
            end else if (cache_valid[rch]) begin
                r.channel = rch;
                r.raw     = cache_raw[rch];
                r.cal     = cache_cal[rch];
            end
            r.count = msg_count;
        end else begin
            case (top_mode)
                WALK_TAG: begin
                    st = absorb_varint(b);
                    if (st == VARINT_BAD) begin
                        void'(drain_varint());
                        top_mode = WALK_HALT;
                    end else if (st == VARINT_DONE) begin
                        v = drain_varint();
                        tag_word = v[FW-1:0];
                        case (tag_word[2:0])
                            pbsr_pkg::WT_VARINT: top_mode = WALK_VARINT;
                            pbsr_pkg::WT_LEN:    top_mode = WALK_LEN;
                            pbsr_pkg::WT_FIXED32: begin
                                skip_left = 32'(pbsr_pkg::FIXED_BYTES);
                                top_mode  = WALK_SKIP;
                            end
                            default:   top_mode = WALK_HALT;
                        endcase
                    end
                end
                WALK_VARINT: begin
                    st = absorb_varint(b);
                    if (st == VARINT_BAD) begin
                        void'(drain_varint());
                        top_mode = WALK_HALT;
                    end else if (st == VARINT_DONE) begin
                        void'(drain_varint());
                        top_mode = WALK_TAG;
                    end
                end
                WALK_LEN: begin
                    st = absorb_varint(b);
                    if (st == VARINT_BAD) begin
                        void'(drain_varint());
                        top_mode = WALK_HALT;
                    end else if (st == VARINT_DONE) begin
                        v = drain_varint();
                        if (v > LEN_LIMIT) begin
                            top_mode = WALK_HALT;
                        end else if (field_of_tag() == pbsr_pkg::FIELD_READING) begin
                            stg_channel = '0;
                            stg_raw     = '0;
                            stg_cal     = '0;
                            if (v == 64'd0) begin
                                upd      = store_reading();
                                top_mode = WALK_TAG;
                            end else begin
                                sub_left = v[31:0];
                                sub_mode = WALK_TAG;
                                top_mode = WALK_SUB;
                            end
                        end else if (v == 64'd0) begin
                            top_mode = WALK_TAG;
                        end else begin
                            skip_left = v[31:0];
                            top_mode  = WALK_SKIP;
                        end
                    end
                end
                WALK_SKIP: begin
                    if (skip_left > 0) skip_left = skip_left - 1;
                    if (skip_left == 0) top_mode = WALK_TAG;
                end
                WALK_SUB: begin
                    if (sub_left > 0) sub_left = sub_left - 1;
                    walk_sub_byte(b);
                    // end of the sub-message commits whatever was staged
                    if (sub_left == 0) begin
                        upd = store_reading();
                        void'(drain_varint());
                        skip_left = '0;
                        sub_mode  = WALK_TAG;
                        top_mode  = WALK_TAG;
                    end
                end
                default: ;
            endcase
            if (upd) begin
                r.updated = 1'b1;
                r.channel = stg_channel;
                r.raw     = stg_raw;
                r.cal     = stg_cal;
            end
            if (last) begin
                msg_count = msg_count + 32'd1;
                clear_walk();
                r.done = 1'b1;
            end
            r.count = msg_count;
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            fail_total++;
        end
    endfunction

    initial fail_total = 0;

    // result beats are checked before the input beat of the same edge is predicted
    always @(posedge i_clk) begin : monitor
        t_reading_beat want;
        if (!i_rst_n) begin
            predicted_readings.delete();
            reset_model();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_readings.size() == 0) begin
                    $error("result beat with no prediction pending");
                    fail_total++;
                end else begin
                    want = predicted_readings.pop_front();
                    compare_field("updated", 32'(want.updated), 32'(i_updated));
                    compare_field("channel_number", 32'(want.channel), 32'(i_channel_number));
                    compare_field("raw_reading", want.raw, i_raw_reading);
                    compare_field("calibrated_bits", want.cal, i_calibrated_bits);
                    compare_field("message_done", 32'(want.done), 32'(i_message_done));
                    compare_field("message_count", want.count, i_message_count);
                    compare_field("bad_channel", 32'(want.bad), 32'(i_bad_channel));
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_beat(i_command, i_data_byte, i_last_byte, i_read_channel, want);
                predicted_readings.push_back(want);
            end
        end
        o_pending <= predicted_readings.size();
    end

endmodule

// ===== tb/protobuf_sensor_reading_parser_unit_test.sv =====
`timescale 1ns / 100ps
// top of the sensor reading parser testbench: clock, reset, byte and read beat stimulus
// with random idling on both sides, and the verdict
// depends on pbsr_pkg, protobuf_sensor_reading_parser_unit and pbsr_reading_checker
module protobuf_sensor_reading_parser_unit_test;

    localparam int CHANNELS     = 4;
    localparam int LENGTH_BITS  = 16;
    localparam int HALF_PERIOD  = 4;
    localparam int SRC_BEATS    = 950;
    localparam int QUIET_TAIL   = 120;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int RUN_LIMIT    = 200000;

    // wire types the parser must reject
    localparam bit [2:0] BAD_WIRE [5] = '{3'd1, 3'd3, 3'd4, 3'd6, 3'd7};

    typedef bit [7:0] t_byte_q [$];

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  read_channel;
    logic        out_valid;
    logic        out_ready;
    logic        updated;
    logic [7:0]  channel_number;
    logic [31:0] raw_reading;
    logic [31:0] calibrated_bits;
    logic        message_done;
    logic [31:0] message_count;
    logic        bad_channel;

    int          fail_count;
    int          pending;
    int          beats_sent = 0;
    int          cycle_count = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_req = 1'b0;

    protobuf_sensor_reading_parser_unit #(
        .CHANNELS    (CHANNELS),
        .LENGTH_BITS (LENGTH_BITS)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_command         (command),
        .i_data_byte       (data_byte),
        .i_last_byte       (last_byte),
        .i_read_channel    (read_channel),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_updated         (updated),
        .o_channel_number  (channel_number),
        .o_raw_reading     (raw_reading),
        .o_calibrated_bits (calibrated_bits),
        .o_message_done    (message_done),
        .o_message_count   (message_count),
        .o_bad_channel     (bad_channel)
    );

    pbsr_reading_checker #(
        .CHANNELS    (CHANNELS),
        .LENGTH_BITS (LENGTH_BITS)
    ) checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_command         (command),
        .i_data_byte       (data_byte),
        .i_last_byte       (last_byte),
        .i_read_channel    (read_channel),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_updated         (updated),
        .i_channel_number  (channel_number),
        .i_raw_reading     (raw_reading),
        .i_calibrated_bits (calibrated_bits),
        .i_message_done    (message_done),
        .i_message_count   (message_count),
        .i_bad_channel     (bad_channel),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // result side: one long hold on request, short random stalls otherwise
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // varint, optionally padded with redundant continuation bytes
    function automatic t_byte_q encode_varint(bit [63:0] value, int min_len);
        t_byte_q q;
        while (value > 64'd127 || q.size() + 1 < min_len) begin
            q.push_back({1'b1, value[6:0]});
            value = value >> 7;
        end
        q.push_back({1'b0, value[6:0]});
        return q;
    endfunction

    function automatic bit [63:0] rand_wide();
        bit [63:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, 63);
    endfunction

    function automatic int rand_pad();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 1;
    endfunction

    // tag varint; bits above the field/type word are sometimes set
    function automatic t_byte_q tag_bytes(bit [31:0] field, bit [2:0] wt);
        bit [63:0] v;
        v = {29'd0, field, wt};
        if ($urandom_range(0, 15) == 0) v[63:35] = 29'($urandom) | 29'd1;
        return encode_varint(v, rand_pad());
    endfunction

    function automatic bit [31:0] rand_field();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 15);
            1:       return $urandom_range(0, 2047);
            2:       return $urandom;
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
    endfunction

    function automatic t_byte_q rand_bytes(int n);
        t_byte_q q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic t_byte_q unending_varint();
        t_byte_q q;
        repeat (10) q.push_back({1'b1, 7'($urandom)});
        return q;
    endfunction

    function automatic t_byte_q reading_field(t_byte_q body, int declared);
        return {tag_bytes(pbsr_pkg::FIELD_READING, pbsr_pkg::WT_LEN),
                encode_varint(64'(declared), rand_pad()), body};
    endfunction

    // contents of a reading: channel, raw, calibrated and unknown fields in any order
    function automatic t_byte_q reading_body();
        t_byte_q   body;
        bit [63:0] ch;
        int        n;
        n = $urandom_range(0, 4);
        if ($urandom_range(0, 3) != 0) n = n + 1;
        repeat (n) begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    ch = ($urandom_range(0, 4) != 0) ? 64'($urandom_range(0, CHANNELS + 1))
                                                     : rand_wide();
                    body = {body, tag_bytes(pbsr_pkg::FIELD_CHANNEL, pbsr_pkg::WT_VARINT),
                            encode_varint(ch, rand_pad())};
                end
                2: body = {body, tag_bytes(pbsr_pkg::FIELD_RAW, pbsr_pkg::WT_VARINT),
                           encode_varint(rand_wide(), rand_pad())};
                3, 4: body = {body, tag_bytes(pbsr_pkg::FIELD_CAL, pbsr_pkg::WT_FIXED32),
                              rand_bytes(4)};
                5: body = {body, tag_bytes(rand_field(), pbsr_pkg::WT_VARINT),
                           encode_varint(rand_wide(), 1)};
                6: body = {body, tag_bytes(rand_field(), pbsr_pkg::WT_FIXED32), rand_bytes(4)};
                default: begin
                    n = $urandom_range(0, 3);
                    body = {body, tag_bytes(rand_field(), pbsr_pkg::WT_LEN),
                            encode_varint(64'(n), 1), rand_bytes(n)};
                end
            endcase
        end
        return body;
    endfunction

    // well-formed top-level field
    function automatic t_byte_q good_field();
        t_byte_q   body;
        bit [31:0] f;
        int        n;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: begin
                body = reading_body();
                return reading_field(body, body.size());
            end
            4: return {tag_bytes(rand_field(), pbsr_pkg::WT_VARINT),
                       encode_varint(rand_wide(), rand_pad())};
            5: return {tag_bytes(rand_field(), pbsr_pkg::WT_FIXED32), rand_bytes(4)};
            6: begin
                f = rand_field();
                if (f == pbsr_pkg::FIELD_READING) f = pbsr_pkg::FIELD_CAL;
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 6);
                return {tag_bytes(f, pbsr_pkg::WT_LEN), encode_varint(64'(n), rand_pad()),
                        rand_bytes(n)};
            end
            default: return reading_field(body, 0);
        endcase
    endfunction

    // top-level field carrying one fault
    function automatic t_byte_q bad_field();
        t_byte_q body;
        int      k;
        case ($urandom_range(0, 7))
            0: return unending_varint();
            1: return {tag_bytes(rand_field(), BAD_WIRE[$urandom_range(0, 4)]),
                       rand_bytes($urandom_range(0, 3))};
            2: return {tag_bytes(rand_field(), pbsr_pkg::WT_LEN),
                       encode_varint((64'd1 << LENGTH_BITS) + ($urandom_range(0, 1) ?
                                     64'($urandom_range(0, 9)) : rand_wide()), 1),
                       rand_bytes(2)};
            // longest legal length, always cut by the message end
            3: return {tag_bytes($urandom_range(0, 1) ? pbsr_pkg::FIELD_READING : rand_field(),
                                 pbsr_pkg::WT_LEN),
                       encode_varint((64'd1 << LENGTH_BITS) - 64'd1, 1), rand_bytes(3)};
            4: begin
                body = {reading_body(), tag_bytes(rand_field(), BAD_WIRE[$urandom_range(0, 4)]),
                        reading_body()};
                return reading_field(body, body.size());
            end
            5: begin
                body = {reading_body(), unending_varint(), reading_body()};
                return reading_field(body, body.size());
            end
            // inner skip reaching the end of the sub-message or past it
            6: begin
                k = $urandom_range(0, 3);
                body = {reading_body(), tag_bytes(rand_field(), pbsr_pkg::WT_LEN),
                        encode_varint(64'(k + $urandom_range(0, 2)), 1), rand_bytes(k)};
                return reading_field(body, body.size());
            end
            // declared length shorter than the contents
            default: begin
                body = reading_body();
                if (body.size() == 0) body = rand_bytes(2);
                return reading_field(body, $urandom_range(0, body.size() - 1));
            end
        endcase
    endfunction

    // one beat; valid rises after an optional gap and stays up until accepted
    task automatic send_beat(input logic cmd, input logic [7:0] b, input logic last,
                             input logic [7:0] rch);
        int gap;
        gap = (tx_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        data_byte    <= b;
        last_byte    <= last;
        read_channel <= rch;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_read();
        bit [7:0] ch;
        ch = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, CHANNELS + 1)) : 8'($urandom);
        send_beat(pbsr_pkg::CMD_READ, 8'($urandom), 1'($urandom), ch);
    endtask

    // message bytes with last on the final one, read beats mixed in at random
    task automatic send_message(input t_byte_q m, input bit mix_reads);
        for (int i = 0; i < m.size(); i++) begin
            if (mix_reads && $urandom_range(0, 9) == 0) send_read();
            send_beat(pbsr_pkg::CMD_BYTE, m[i], i == m.size() - 1, 8'($urandom));
        end
    endtask

    initial begin
        t_byte_q msg;
        int      kind;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= pbsr_pkg::CMD_BYTE;
        data_byte    <= '0;
        last_byte    <= 1'b0;
        read_channel <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: unwritten and out-of-range reads, a full reading with extreme values,
        // an empty reading followed by a bad wire type, then read back
        send_beat(pbsr_pkg::CMD_READ, 8'hFF, 1'b1, 8'd0);
        send_beat(pbsr_pkg::CMD_READ, 8'h00, 1'b0, 8'd255);
        msg = '{8'h12, 8'h0D, 8'h08, 8'h03, 8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
                8'h1D, 8'h00, 8'h00, 8'h80, 8'h7F};
        send_message(msg, 1'b0);
        send_beat(pbsr_pkg::CMD_READ, 8'h00, 1'b0, 8'd3);
        msg = '{8'h12, 8'h00, 8'h0B, 8'hFF};
        send_message(msg, 1'b0);
        send_beat(pbsr_pkg::CMD_READ, 8'h5A, 1'b1, 8'd0);
        send_beat(pbsr_pkg::CMD_READ, 8'hA5, 1'b0, 8'(CHANNELS));

        // random messages; the result side holds off once early on
        hold_req = 1'b1;
        while (beats_sent < SRC_BEATS) begin
            tx_idle = (beats_sent < SRC_BEATS - QUIET_TAIL) && ($urandom_range(0, 4) != 0);
            rx_idle = (beats_sent < SRC_BEATS - QUIET_TAIL) && ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 19);
            msg = {};
            if (kind < 17) begin
                repeat ($urandom_range(1, 3)) msg = {msg, good_field()};
                if (kind >= 14) msg = {msg, bad_field(), good_field()};
                if ($urandom_range(0, 7) == 0) msg = msg[0:$urandom_range(0, msg.size() - 1)];
            end else begin
                msg = rand_bytes($urandom_range(1, 8));
            end
            send_message(msg, 1'b1);
            if ($urandom_range(0, 3) == 0) send_read();
        end
        in_valid <= 1'b0;

        // wait for every predicted result, then let the pipeline settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
